@@ rtl/xoro_pkg.sv @@
// Shared types, operation codes, datapath actions and constants of the xoroshiro128+ generator.
package xoro_pkg;

    localparam logic [1:0] OP_RAW   = 2'd0;
    localparam logic [1:0] OP_BOUND = 2'd1;
    localparam logic [1:0] OP_JUMP  = 2'd2;
    localparam logic [1:0] OP_SEED  = 2'd3;

    localparam logic [3:0] ACT_NONE   = 4'd0;
    localparam logic [3:0] ACT_RAW    = 4'd1;
    localparam logic [3:0] ACT_BSETUP = 4'd2;
    localparam logic [3:0] ACT_BTRY   = 4'd3;
    localparam logic [3:0] ACT_JINIT  = 4'd4;
    localparam logic [3:0] ACT_JSTEP  = 4'd5;
    localparam logic [3:0] ACT_JDONE  = 4'd6;
    localparam logic [3:0] ACT_SINIT  = 4'd7;
    localparam logic [3:0] ACT_MUL    = 4'd8;
    localparam logic [3:0] ACT_ADD    = 4'd9;
    localparam logic [3:0] ACT_STORE  = 4'd10;

    localparam logic [127:0] JUMP_POLY  = 128'hd86b048b86aa9922_beac0467eba5facb;
    localparam logic [63:0]  GOLDEN_INC = 64'h9E3779B97F4A7C15;
    localparam logic [63:0]  MIX_MUL1   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0]  MIX_MUL2   = 64'h94D049BB133111EB;

    typedef struct packed {
        logic [3:0] act;
        logic       sel;
        logic [6:0] step_idx;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       range_err;
        logic       try_ok;
    } t_status;

    function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned k);
        rotl = (v << k) | (v >> (64 - k));
    endfunction

endpackage

@@ rtl/xoro_if.sv @@
// Valid/ready channel interfaces for requests, results and seed writes.
interface xoro_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    modport source (output valid, output op, output low_bound, output high_bound, input ready);
    modport sink (input valid, input op, input low_bound, input high_bound, output ready);
endinterface

interface xoro_out_if;
    logic               valid;
    logic               ready;
    logic [63:0]        raw_value;
    logic signed [31:0] bounded_value;
    logic               range_error;
    modport source (output valid, output raw_value, output bounded_value, output range_error,
                    input ready);
    modport sink (input valid, input raw_value, input bounded_value, input range_error,
                  output ready);
endinterface

interface xoro_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/xoroshiro128plus_prng.sv @@
// Top level of the xoroshiro128+ generator with bounded draws, jump and reseed.
// Every request gives exactly one result. A raw draw leaves the controller idle, so raw
// draws transfer once per cycle while results are taken. A bounded draw takes one set-up
// step and then one try of the 64-bit adder and state update after another, fewer than
// two tries on average; bad bounds give their result after the set-up step alone.
// A jump makes one state update per bit of the 128-bit jump polynomial.
// A reseed runs the 32 by 32 bit multipliers of the splitmix64 mixer for two outputs.
// After reset the block runs the same seeding from seed zero before it accepts a
// request; seed writes are taken at any time.
module xoroshiro128plus_prng (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xoro_in_if.sink     i_in,
    xoro_out_if.source  o_out,
    xoro_cfg_if.sink    i_cfg
);
    import xoro_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic [63:0] raw_value;
    logic [31:0] bounded_value;
    logic        range_error;
    logic        in_ready;
    logic        out_valid;

    assign i_cfg.ready = 1'b1;

    xoro_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (i_in.op),
        .i_low_bound     (i_in.low_bound),
        .i_high_bound    (i_in.high_bound),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_data      (i_cfg.data),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_raw_value     (raw_value),
        .o_bounded_value (bounded_value),
        .o_range_error   (range_error)
    );

    xoro_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    assign i_in.ready = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.raw_value = raw_value;
    assign o_out.bounded_value = bounded_value;
    assign o_out.range_error = range_error;

endmodule

@@ rtl/xoro_dp.sv @@
// Datapath: generator state, jump accumulator, splitmix64 mixer, bound logic and result register.
module xoro_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_op,
    input  logic [31:0]          i_low_bound,
    input  logic [31:0]          i_high_bound,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_data,
    input  xoro_pkg::t_cmd       i_cmd,
    output xoro_pkg::t_status    o_status,
    output logic [63:0]          o_raw_value,
    output logic [31:0]          o_bounded_value,
    output logic                 o_range_error
);
    import xoro_pkg::*;

    logic [31:0] r_seed;
    logic [63:0] r_s0, r_s1, n_s0, n_s1;
    logic [63:0] r_acc0, r_acc1, n_acc0, n_acc1;
    logic [63:0] r_ctr, n_ctr, r_z, n_z;
    logic [63:0] r_pll, n_pll;
    logic [31:0] r_plh, n_plh, r_phl, n_phl;
    logic [31:0] r_lo, n_lo;
    logic [30:0] r_diff, n_diff, r_mask, n_mask;
    logic [63:0] r_raw;
    logic [31:0] r_bval;
    logic        r_err;

    logic [63:0] sum, b_x, adv0, adv1, mix_x, mix_c, mix_out, ctr_inc, seed_ext;
    logic [32:0] diff;
    logic [30:0] smear, try_v;
    logic        bad_range, try_ok;

    always_comb begin
        sum  = r_s0 + r_s1;
        b_x  = r_s0 ^ r_s1;
        adv0 = rotl(r_s0, 55) ^ b_x ^ (b_x << 14);
        adv1 = rotl(b_x, 36);

        diff = {i_high_bound[31], i_high_bound} - {i_low_bound[31], i_low_bound};
        bad_range = diff[32] | diff[31];
        smear = diff[30:0];
        smear = smear | (smear >> 1);
        smear = smear | (smear >> 2);
        smear = smear | (smear >> 4);
        smear = smear | (smear >> 8);
        smear = smear | (smear >> 16);

        try_v  = sum[30:0] & r_mask;
        try_ok = (try_v <= r_diff);

        mix_x   = i_cmd.sel ? (r_z ^ (r_z >> 27)) : (r_z ^ (r_z >> 30));
        mix_c   = i_cmd.sel ? MIX_MUL2 : MIX_MUL1;
        mix_out = r_z ^ (r_z >> 31);
        ctr_inc = r_ctr + GOLDEN_INC;
        seed_ext = {{32{r_seed[31]}}, r_seed};
    end

    always_comb begin
        n_s0 = r_s0;
        n_s1 = r_s1;
        n_acc0 = r_acc0;
        n_acc1 = r_acc1;
        n_ctr = r_ctr;
        n_z = r_z;
        n_pll = r_pll;
        n_plh = r_plh;
        n_phl = r_phl;
        n_lo = r_lo;
        n_diff = r_diff;
        n_mask = r_mask;
        case (i_cmd.act)
            ACT_RAW, ACT_BTRY: begin
                n_s0 = adv0;
                n_s1 = adv1;
            end
            ACT_BSETUP: begin
                n_lo = i_low_bound;
                n_diff = diff[30:0];
                n_mask = smear;
            end
            ACT_JINIT: begin
                n_acc0 = '0;
                n_acc1 = '0;
            end
            ACT_JSTEP: begin
                if (JUMP_POLY[i_cmd.step_idx]) begin
                    n_acc0 = r_acc0 ^ r_s0;
                    n_acc1 = r_acc1 ^ r_s1;
                end
                n_s0 = adv0;
                n_s1 = adv1;
            end
            ACT_JDONE: begin
                n_s0 = r_acc0;
                n_s1 = r_acc1;
            end
            ACT_SINIT: begin
                n_ctr = seed_ext + GOLDEN_INC;
                n_z = seed_ext + GOLDEN_INC;
            end
            ACT_MUL: begin
                n_pll = {32'd0, mix_x[31:0]} * {32'd0, mix_c[31:0]};
                n_plh = 32'(mix_x[31:0] * mix_c[63:32]);
                n_phl = 32'(mix_x[63:32] * mix_c[31:0]);
            end
            ACT_ADD: begin
                n_z = r_pll + {r_plh + r_phl, 32'd0};
            end
            ACT_STORE: begin
                if (i_cmd.sel) begin
                    n_s1 = mix_out;
                end else begin
                    n_s0 = mix_out;
                end
                n_ctr = ctr_inc;
                n_z = ctr_inc;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
        r_s1 <= n_s1;
        r_acc0 <= n_acc0;
        r_acc1 <= n_acc1;
        r_ctr <= n_ctr;
        r_z <= n_z;
        r_pll <= n_pll;
        r_plh <= n_plh;
        r_phl <= n_phl;
        r_lo <= n_lo;
        r_diff <= n_diff;
        r_mask <= n_mask;
        if (i_cmd.out_load) begin
            r_raw <= (i_cmd.act == ACT_RAW) ? sum : 64'd0;
            r_bval <= (i_cmd.act == ACT_BTRY) ? (r_lo + {1'b0, try_v}) : 32'd0;
            r_err <= (i_cmd.act == ACT_BSETUP);
        end
    end

    assign o_status.op = i_op;
    assign o_status.range_err = bad_range;
    assign o_status.try_ok = try_ok;
    assign o_raw_value = r_raw;
    assign o_bounded_value = r_bval;
    assign o_range_error = r_err;

endmodule

@@ rtl/xoro_ctrl.sv @@
// Controller: sequences each operation and owns the request and result handshakes.
module xoro_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    input  xoro_pkg::t_status    i_status,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output xoro_pkg::t_cmd       o_cmd
);
    import xoro_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_BTRY  = 4'd1;
    localparam logic [3:0] ST_JSTEP = 4'd2;
    localparam logic [3:0] ST_JDONE = 4'd3;
    localparam logic [3:0] ST_SINIT = 4'd4;
    localparam logic [3:0] ST_MUL1  = 4'd5;
    localparam logic [3:0] ST_ADD1  = 4'd6;
    localparam logic [3:0] ST_MUL2  = 4'd7;
    localparam logic [3:0] ST_ADD2  = 4'd8;
    localparam logic [3:0] ST_STORE = 4'd9;

    logic [3:0] r_state, n_state;
    logic [6:0] r_idx, n_idx;
    logic       r_word, n_word;
    logic       r_boot, n_boot;
    logic       r_out_valid, n_out_valid;
    logic       in_ready, accept;

    assign in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept = in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_word = r_word;
        n_boot = r_boot;
        o_cmd.act = ACT_NONE;
        o_cmd.sel = 1'b0;
        o_cmd.step_idx = r_idx;
        o_cmd.out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_status.op)
                        OP_RAW: begin
                            o_cmd.act = ACT_RAW;
                            o_cmd.out_load = 1'b1;
                        end
                        OP_BOUND: begin
                            o_cmd.act = ACT_BSETUP;
                            if (i_status.range_err) begin
                                o_cmd.out_load = 1'b1;
                            end else begin
                                n_state = ST_BTRY;
                            end
                        end
                        OP_JUMP: begin
                            o_cmd.act = ACT_JINIT;
                            n_idx = '0;
                            n_state = ST_JSTEP;
                        end
                        default: begin
                            o_cmd.act = ACT_SINIT;
                            n_word = 1'b0;
                            n_state = ST_MUL1;
                        end
                    endcase
                end
            end
            ST_BTRY: begin
                o_cmd.act = ACT_BTRY;
                if (i_status.try_ok) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_JSTEP: begin
                o_cmd.act = ACT_JSTEP;
                n_idx = r_idx + 7'd1;
                if (&r_idx) begin
                    n_state = ST_JDONE;
                end
            end
            ST_JDONE: begin
                o_cmd.act = ACT_JDONE;
                o_cmd.out_load = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SINIT: begin
                o_cmd.act = ACT_SINIT;
                n_word = 1'b0;
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.act = ACT_MUL;
                n_state = ST_ADD1;
            end
            ST_ADD1: begin
                o_cmd.act = ACT_ADD;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.act = ACT_MUL;
                o_cmd.sel = 1'b1;
                n_state = ST_ADD2;
            end
            ST_ADD2: begin
                o_cmd.act = ACT_ADD;
                n_state = ST_STORE;
            end
            ST_STORE: begin
                o_cmd.act = ACT_STORE;
                o_cmd.sel = r_word;
                if (r_word) begin
                    o_cmd.out_load = !r_boot;
                    n_boot = 1'b0;
                    n_state = ST_IDLE;
                end else begin
                    n_word = 1'b1;
                    n_state = ST_MUL1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SINIT;
            r_idx <= '0;
            r_word <= 1'b0;
            r_boot <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_word <= n_word;
            r_boot <= n_boot;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready = in_ready;
    assign o_out_valid = r_out_valid;

endmodule

@@ tb/sv/xoro_draw_checker.sv @@
// Checker that predicts every generator result from the observed transfers and compares them.
module xoro_draw_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    xoro_in_if   i_req,
    xoro_out_if  i_res,
    xoro_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import xoro_pkg::*;

    localparam logic [127:0] JUMP_MASK = 128'hd86b048b86aa9922_beac0467eba5facb;
    localparam logic [63:0]  WEYL_STEP = 64'h9E3779B97F4A7C15;
    localparam logic [63:0]  MIX_A     = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0]  MIX_B     = 64'h94D049BB133111EB;

    typedef struct packed {
        logic [63:0]        raw;
        logic signed [31:0] bounded;
        logic               err;
    } t_draw;

    logic [63:0] st0;
    logic [63:0] st1;
    logic [31:0] seed_word;
    t_draw       draws_due[$];
    t_draw       want;

    task automatic log_fail(input string what);
        o_fail_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic logic [63:0] step_state();
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] sum;
        a   = st0;
        b   = st1;
        sum = a + b;
        b   = b ^ a;
        st0 = {a[8:0], a[63:9]} ^ b ^ (b << 14);
        st1 = {b[27:0], b[63:28]};
        return sum;
    endfunction

    function automatic logic [63:0] mix64(input logic [63:0] c);
        logic [63:0] z;
        z = (c ^ (c >> 30)) * MIX_A;
        z = (z ^ (z >> 27)) * MIX_B;
        return z ^ (z >> 31);
    endfunction

    function automatic void load_seed(input logic [31:0] s);
        logic [63:0] ctr;
        ctr = {{32{s[31]}}, s} + WEYL_STEP;
        st0 = mix64(ctr);
        st1 = mix64(ctr + WEYL_STEP);
    endfunction

    function automatic void jump_ahead();
        logic [63:0] acc0;
        logic [63:0] acc1;
        acc0 = '0;
        acc1 = '0;
        for (int i = 0; i < 128; i++) begin
            if (JUMP_MASK[i]) begin
                acc0 ^= st0;
                acc1 ^= st1;
            end
            void'(step_state());
        end
        st0 = acc0;
        st1 = acc1;
    endfunction

    function automatic t_draw predict_draw(input logic [1:0] op, input logic signed [31:0] lo,
                                           input logic signed [31:0] hi);
        t_draw              r;
        logic signed [63:0] lo_w;
        logic signed [63:0] hi_w;
        logic signed [63:0] span;
        logic [63:0]        lim;
        logic [63:0]        mask;
        logic [63:0]        v;
        r = '0;
        case (op)
            OP_RAW: begin
                r.raw = step_state();
            end
            OP_BOUND: begin
                lo_w = lo;
                hi_w = hi;
                span = hi_w - lo_w + 64'sd1;
                if (hi_w < lo_w || span > 64'sh8000_0000) begin
                    r.err = 1'b1;
                end else begin
                    lim  = span;
                    mask = lim - 64'd1;
                    mask |= mask >> 1;
                    mask |= mask >> 2;
                    mask |= mask >> 4;
                    mask |= mask >> 8;
                    mask |= mask >> 16;
                    v = step_state() & mask;
                    while (v >= lim) v = step_state() & mask;
                    r.bounded = lo + v[31:0];
                end
            end
            OP_JUMP: begin
                jump_ahead();
            end
            default: begin
                load_seed(seed_word);
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_word = '0;
            load_seed('0);
            draws_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                seed_word = i_cfg.data;
            end
            if (i_req.valid && i_req.ready) begin
                draws_due.push_back(predict_draw(i_req.op, i_req.low_bound, i_req.high_bound));
            end
            if (i_res.valid && i_res.ready) begin
                if (draws_due.size() == 0) begin
                    log_fail($sformatf("result transfer with nothing outstanding, raw_value %h",
                                       i_res.raw_value));
                end else begin
                    want = draws_due.pop_front();
                    if (i_res.raw_value !== want.raw) begin
                        log_fail($sformatf("raw_value %h, expected %h",
                                           i_res.raw_value, want.raw));
                    end
                    if (i_res.bounded_value !== want.bounded) begin
                        log_fail($sformatf("bounded_value %0d, expected %0d",
                                           i_res.bounded_value, want.bounded));
                    end
                    if (i_res.range_error !== want.err) begin
                        log_fail($sformatf("range_error %b, expected %b",
                                           i_res.range_error, want.err));
                    end
                end
            end
        end
        o_pending <= draws_due.size();
    end

endmodule

@@ tb/sv/xoroshiro128plus_prng_tb.sv @@
// Testbench top for the xoroshiro128+ generator: clock, reset, stimulus and verdict.
module xoroshiro128plus_prng_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xoro_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int QUIET_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 150;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PASS = 63;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int send_idle_pct  = 0;
    int take_stall_pct = 0;
    int quiet_cycles   = 0;
    int fail_count;
    int pending;

    int          send_idle_by_phase[4]  = '{0, 56, 0, 14};
    int          take_stall_by_phase[4] = '{0, 0, 56, 14};
    logic [31:0] seed_extremes[4]       = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                            32'hFFFF_FFFF};

    xoro_in_if  req_if ();
    xoro_out_if res_if ();
    xoro_cfg_if cfg_if ();

    xoroshiro128plus_prng i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .i_cfg   (cfg_if)
    );

    xoro_draw_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .i_cfg        (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            res_if.ready <= ($urandom_range(99) >= take_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("xoroshiro128plus_prng verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input logic [1:0] op, input logic signed [31:0] lo,
                                input logic signed [31:0] hi);
        if ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.op         <= op;
        req_if.low_bound  <= lo;
        req_if.high_bound <= hi;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] s);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= s;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        int                 pick;
        int                 k;
        logic [1:0]         op;
        logic signed [31:0] lo;
        logic signed [31:0] hi;

        req_if.valid      = 1'b0;
        req_if.op         = OP_RAW;
        req_if.low_bound  = '0;
        req_if.high_bound = '0;
        res_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items run from the seed-zero state left by reset.
        send_request(OP_RAW,   32'sd0, 32'sd0);
        send_request(OP_RAW,   32'sd0, 32'sd0);
        send_request(OP_BOUND, 32'sd0, 32'sd0);
        send_request(OP_BOUND, 32'sh8000_0000, 32'sh8000_0000);
        send_request(OP_BOUND, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_request(OP_BOUND, 32'sh8000_0000, -32'sd1);
        send_request(OP_BOUND, 32'sd0, 32'sh7FFF_FFFF);
        send_request(OP_BOUND, 32'sh8000_0000, 32'sd0);
        send_request(OP_BOUND, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_request(OP_BOUND, 32'sd5, 32'sd4);
        send_request(OP_BOUND, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_request(OP_BOUND, 32'sd0, 32'sd2);
        send_request(OP_BOUND, -32'sd1, 32'sd1);
        send_request(OP_BOUND, 32'sd100, 32'sd65636);
        send_request(OP_RAW,   -32'sd1, -32'sd1);
        send_request(OP_JUMP,  32'sh1234_5678, -32'sd77);
        send_request(OP_RAW,   32'sd0, 32'sd0);
        send_request(OP_SEED,  -32'sd1, 32'sd0);
        send_request(OP_RAW,   32'sd0, 32'sd0);
        send_request(OP_BOUND, -32'sd1000, 32'sd1000);
        send_request(OP_JUMP,  32'sd0, 32'sd0);
        send_request(OP_SEED,  32'sd0, 32'sd0);
        send_request(OP_RAW,   32'sd0, 32'sd0);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            send_idle_pct  = send_idle_by_phase[phase % 4];
            take_stall_pct = take_stall_by_phase[phase % 4];
            write_seed((phase < 4) ? seed_extremes[phase] : $urandom);
            send_request(OP_SEED, $urandom, $urandom);
            for (int n = 0; n < ITEMS_PER_PASS; n++) begin
                pick = $urandom_range(99);
                lo   = $urandom;
                hi   = $urandom;
                if (pick < 40) begin
                    op = OP_RAW;
                end else if (pick < 90) begin
                    op = OP_BOUND;
                    case ($urandom_range(9))
                        0, 1, 2, 3: begin
                            hi = lo + $urandom_range(63);
                        end
                        4: begin
                            k  = $urandom_range(31);
                            hi = lo + (32'd1 << k) - 32'd2 + $urandom_range(2);
                        end
                        5: begin
                            lo = 32'h8000_0000 + $urandom_range(32'h7FFF_FFFE);
                            hi = lo + 32'h7FFF_FFFF + $urandom_range(1);
                        end
                        6: begin
                            hi = lo - $urandom_range(1000, 1);
                        end
                        7: begin
                        end
                        default: begin
                            lo = $urandom_range(20) - 10;
                            hi = lo + $urandom_range(20);
                        end
                    endcase
                end else if (pick < 95) begin
                    op = OP_JUMP;
                end else begin
                    op = OP_SEED;
                end
                send_request(op, lo, hi);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("xoroshiro128plus_prng verification clean");
        end else begin
            $display("xoroshiro128plus_prng verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/xoro_pkg.sv
rtl/xoro_if.sv
rtl/xoro_dp.sv
rtl/xoro_ctrl.sv
rtl/xoroshiro128plus_prng.sv
tb/sv/xoro_draw_checker.sv
tb/sv/xoroshiro128plus_prng_tb.sv
